[hw/rtl/posting_gap_vbyte_encoder_core_assert.svh]
// Assertion macros for the posting gap vbyte encoder.
// Each expects clk and rst_n to be visible where it is used.
`ifndef POSTING_GAP_VBYTE_ENCODER_CORE_ASSERT_SVH
`define POSTING_GAP_VBYTE_ENCODER_CORE_ASSERT_SVH

// condition holds on every cycle out of reset
`define PGVE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define PGVE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PGVE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pgve_pkg.sv]
// Shared types, constants and helpers for the posting gap vbyte encoder.
// No dependencies.
package pgve_pkg;

  localparam int PGVE_BLOCK_LEN   = 128;
  localparam int PGVE_QUEUE_DEPTH = 2;
  localparam int PGVE_MAX_BYTES   = 5;
  localparam int PGVE_CNT_W       = 3;

  localparam logic [31:0] PGVE_LIM1 = 32'd1 << 7;
  localparam logic [31:0] PGVE_LIM2 = 32'd1 << 14;
  localparam logic [31:0] PGVE_LIM3 = 32'd1 << 21;
  localparam logic [31:0] PGVE_LIM4 = 32'd1 << 28;

  // configuration register indexes
  localparam logic PGVE_CFG_APPLY_DELTA   = 1'b0;
  localparam logic PGVE_CFG_BLOCK_RESTART = 1'b1;

  typedef struct packed {
    logic apply_delta;
    logic block_restart;
  } pgve_cfg_t;

  typedef struct packed {
    logic [31:0]           word;
    logic [PGVE_CNT_W-1:0] nbytes;
  } pgve_entry_t;

  // shortest vbyte length of a word
  function automatic logic [PGVE_CNT_W-1:0] pgve_byte_count(input logic [31:0] w);
    logic [PGVE_CNT_W-1:0] n;
    if (w < PGVE_LIM1)      n = PGVE_CNT_W'(1);
    else if (w < PGVE_LIM2) n = PGVE_CNT_W'(2);
    else if (w < PGVE_LIM3) n = PGVE_CNT_W'(3);
    else if (w < PGVE_LIM4) n = PGVE_CNT_W'(4);
    else                    n = PGVE_CNT_W'(PGVE_MAX_BYTES);
    return n;
  endfunction

endpackage

[hw/rtl/pgve_front.sv]
// Front end: accepts posting values, forms the gap word and its byte count.
// Depends on pgve_pkg.
module pgve_front #(
  parameter int BLOCK_LEN = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pgve_pkg::pgve_cfg_t   cfg,
  input  logic                  in_fire,
  input  logic [31:0]           in_value,
  input  logic                  in_last,
  output pgve_pkg::pgve_entry_t entry
);
  import pgve_pkg::*;

  localparam int PW = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;

  logic [31:0]   prev_r;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          started_r;
  logic [PW:0]   pos_inc;
  logic          fresh;
  logic [31:0]   word;

  always_comb begin
    pos_inc = {1'b0, pos_r} + (PW+1)'(1);
    if (!started_r) begin
      pos_nxt = '0;
    end else if (pos_inc >= (PW+1)'(BLOCK_LEN)) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_inc[PW-1:0];
    end
    // first item of a list, or of a block when restarting
    fresh = !started_r || (cfg.block_restart && (pos_nxt == '0));
    word  = (cfg.apply_delta && !fresh) ? (in_value - prev_r) : in_value;
    entry.word   = word;
    entry.nbytes = pgve_byte_count(word);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r    <= '0;
      pos_r     <= '0;
      started_r <= 1'b0;
    end else if (in_fire) begin
      prev_r    <= in_value;
      pos_r     <= pos_nxt;
      started_r <= !in_last;
    end
  end

endmodule

[hw/rtl/pgve_queue.sv]
// Small register queue between front and back ends.
// Depends on pgve_pkg.
module pgve_queue #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  pgve_pkg::pgve_entry_t push_data,
  input  logic                  pop,
  output pgve_pkg::pgve_entry_t head,
  output logic                  not_empty,
  output logic                  full
);
  import pgve_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pgve_entry_t   mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == CW'(DEPTH));
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[hw/rtl/pgve_back.sv]
// Back end: takes queued words and emits their vbyte code one byte a cycle while out_tready allows.
// Depends on pgve_pkg and posting_gap_vbyte_encoder_core_assert.svh.
module pgve_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pgve_pkg::pgve_entry_t head,
  input  logic                  q_valid,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,   // [7:0] code_byte
  output logic                  out_tlast    // last_byte
);
  import pgve_pkg::*;
  `include "posting_gap_vbyte_encoder_core_assert.svh"

  logic [31:0]           sh_r, sh_nxt;
  logic [PGVE_CNT_W-1:0] rem_r, rem_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_data_r, out_data_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_free, emit, fin;

  always_comb begin
    out_free = !out_valid_r || out_tready;
    emit     = (rem_r != '0) && out_free;
    fin      = (rem_r == PGVE_CNT_W'(1));
    // refill the word register when it is empty or as its final byte leaves
    q_pop    = q_valid && ((rem_r == '0) || (fin && emit));

    sh_nxt  = sh_r;
    rem_nxt = rem_r;
    if (q_pop) begin
      sh_nxt  = head.word;
      rem_nxt = head.nbytes;
    end else if (emit) begin
      sh_nxt  = sh_r >> 7;
      rem_nxt = rem_r - PGVE_CNT_W'(1);
    end

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (out_free) begin
      out_valid_nxt = emit;
      out_data_nxt  = {fin, sh_r[6:0]};
      out_last_nxt  = fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r       <= sh_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `PGVE_ASSERT_IMPL(a_stop_bit, out_valid_r, out_data_r[7] == out_last_r, "stop bit mismatch")
  `PGVE_ASSERT_ALWAYS(a_rem_range, rem_r <= PGVE_CNT_W'(PGVE_MAX_BYTES), "byte count overrun")
  `PGVE_ASSERT_NEXT(a_drain, emit && fin && !q_pop, rem_r == '0, "word not drained")
  `PGVE_ASSERT_IMPL(a_pop_len, q_pop, head.nbytes != '0, "queued word with no bytes")

endmodule

[hw/rtl/posting_gap_vbyte_encoder_core.sv]
// Posting gap vbyte encoder: one posting value in, 1 to 5 code bytes out.
// A value's first byte passes the queue, the word register and the output register before it is valid.
// Rates: one value per cycle into the queue while it is not full; the byte-wide output
// port sends one byte per cycle while out_tready is high, as many bytes as the code length.
// Reset (rst_n low, synchronous): queue emptied, gap state cleared,
// apply_delta = 1, block_restart = 0.
module posting_gap_vbyte_encoder_core #(
  parameter int BLOCK_LEN   = pgve_pkg::PGVE_BLOCK_LEN,
  parameter int QUEUE_DEPTH = pgve_pkg::PGVE_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic        cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] value
  input  logic        in_tlast,    // last_in_list
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] code_byte
  output logic        out_tlast    // last_byte
);
  import pgve_pkg::*;

  pgve_cfg_t   cfg_r;
  pgve_entry_t fe_entry, q_head;
  logic        q_full, q_valid, q_pop, in_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.apply_delta   <= 1'b1;
      cfg_r.block_restart <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        PGVE_CFG_APPLY_DELTA:   cfg_r.apply_delta   <= cfg_wdata;
        PGVE_CFG_BLOCK_RESTART: cfg_r.block_restart <= cfg_wdata;
        default:                cfg_r <= cfg_r;
      endcase
    end
  end

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  pgve_front #(
    .BLOCK_LEN (BLOCK_LEN)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_fire  (in_fire),
    .in_value (in_tdata),
    .in_last  (in_tlast),
    .entry    (fe_entry)
  );

  pgve_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_data (fe_entry),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_valid),
    .full      (q_full)
  );

  pgve_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[test/posting_gap_vbyte_encoder_core_tb.sv]
// Self-checking testbench for posting_gap_vbyte_encoder_core: drives posting values,
// predicts the gap and vbyte bytes in the bench and checks every output item.
// Depends on pgve_pkg and the encoder core RTL.
module posting_gap_vbyte_encoder_core_tb;
  import pgve_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;  // cycles with no item moving on either side
  localparam int HOLD_CYCLES = 250;   // long output back-pressure stretch

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_byte;
  } vbyte_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_addr;
  logic        cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] value
  logic        in_tlast;   // last_in_list
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [7:0] code_byte
  logic        out_tlast;  // last_byte

  // expected code bytes, oldest first
  vbyte_t      code_bytes_q[$];

  // gap coder state mirrored in the bench
  logic        apply_delta_q;
  logic        block_restart_q;
  logic [31:0] prev_value_q;
  int          block_pos_q;
  logic        in_list_q;

  int          n_fail;
  int          idle_cycles;
  int          send_idle_pct;
  int          stall_pct;
  int          hold_left;
  int          list_left;
  logic [31:0] stim_prev;

  posting_gap_vbyte_encoder_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  // gap conversion plus vbyte split for one accepted posting value
  function automatic void encode_posting(input logic [31:0] value, input logic last);
    logic        fresh;
    logic [31:0] word;
    int          nbytes;
    vbyte_t      b;
    if (!in_list_q) begin
      block_pos_q = 0;
      fresh = 1'b1;
    end else begin
      block_pos_q = block_pos_q + 1;
      if (block_pos_q >= PGVE_BLOCK_LEN) block_pos_q = 0;
      fresh = block_restart_q && (block_pos_q == 0);
    end
    word = (apply_delta_q && !fresh) ? value - prev_value_q : value;
    prev_value_q = value;
    in_list_q = !last;
    nbytes = 1;
    while (nbytes < 5 && (word >> (7 * nbytes)) != 32'd0) nbytes++;
    for (int k = 0; k < nbytes; k++) begin
      b.last_byte = (k == nbytes - 1);
      b.code_byte = {b.last_byte, 7'((word >> (7 * k)) & 32'h7f)};
      code_bytes_q.push_back(b);
    end
  endfunction

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (code_bytes_q.size() == 0) begin
        $error("unexpected output item: code_byte %h last_byte %b", out_tdata, out_tlast);
        n_fail++;
      end else begin
        vbyte_t exp_b;
        exp_b = code_bytes_q.pop_front();
        if (out_tdata !== exp_b.code_byte) begin
          $error("code_byte: expected %h, got %h", exp_b.code_byte, out_tdata);
          n_fail++;
        end
        if (out_tlast !== exp_b.last_byte) begin
          $error("last_byte: expected %b, got %b", exp_b.last_byte, out_tlast);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("posting_gap_vbyte_encoder_core: mismatch");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [31:0] value, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    encode_posting(value, last);
  endtask

  task automatic write_reg(input logic idx, input logic val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      PGVE_CFG_APPLY_DELTA:   apply_delta_q = val;
      PGVE_CFG_BLOCK_RESTART: block_restart_q = val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (code_bytes_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // idle rates are changed off the falling edge the receiver samples them on
  task automatic set_idling(input int send_pct, input int recv_pct, input int hold);
    @(posedge clk);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    hold_left     = hold;
    @(negedge clk);
  endtask

  // gap with a random code length
  function automatic logic [31:0] random_gap();
    int k;
    k = $urandom_range(0, 4);
    if (k == 4) return $urandom;
    return $urandom & ((32'd1 << (7 * (k + 1))) - 32'd1);
  endfunction

  // mostly ascending lists with random gaps; some noise and descending values
  task automatic send_lists(input int n_items, input int long_len);
    logic [31:0] v;
    int          r;
    if (long_len > 0) list_left = long_len;
    for (int i = 0; i < n_items; i++) begin
      if (list_left == 0) list_left = $urandom_range(1, 12);
      r = $urandom_range(0, 99);
      if (r < 10)      v = $urandom;
      else if (r < 15) v = stim_prev - 32'($urandom_range(1, 1000));
      else             v = stim_prev + random_gap();
      list_left--;
      send_item(v, list_left == 0);
      stim_prev = v;
    end
    in_tvalid <= 1'b0;
  endtask

  // reset config: gaps on, no block restart; wrap and single-item list
  task automatic test_reset_defaults();
    send_item(32'd5, 1'b0);
    send_item(32'd133, 1'b0);
    send_item(32'd133, 1'b0);
    send_item(32'd10, 1'b0);          // smaller than previous, wraps
    send_item(32'hffff_ffff, 1'b1);
    send_item(32'd300, 1'b1);         // list of one item
    send_item(32'd1000, 1'b0);        // list left open
    wait_idle();
  endtask

  // register change while a list is open applies from the next item
  task automatic test_config_mid_list();
    write_reg(PGVE_CFG_APPLY_DELTA, 1'b0);
    send_item(32'h1234_5678, 1'b0);
    wait_idle();
    write_reg(PGVE_CFG_APPLY_DELTA, 1'b1);
    send_item(32'h1234_5679, 1'b1);
    wait_idle();
  endtask

  // raw values on both sides of each code length boundary
  task automatic test_byte_lengths();
    logic [31:0] vals[10];
    vals = '{32'd0, 32'd127, 32'd128, 32'd16383, 32'd16384, 32'h1f_ffff, 32'h20_0000,
             32'h0fff_ffff, 32'h1000_0000, 32'hffff_ffff};
    write_reg(PGVE_CFG_APPLY_DELTA, 1'b0);
    foreach (vals[i]) send_item(vals[i], i[0]);
    wait_idle();
  endtask

  // long list crosses a block boundary with restart on
  task automatic test_block_restart();
    write_reg(PGVE_CFG_APPLY_DELTA, 1'b1);
    write_reg(PGVE_CFG_BLOCK_RESTART, 1'b1);
    set_idling(20, 47, 0);
    send_lists(150, $urandom_range(130, 140));
    wait_idle();
  endtask

  task automatic test_raw_random();
    write_reg(PGVE_CFG_APPLY_DELTA, 1'b0);
    set_idling(47, 20, 0);
    send_lists(50, 0);
    wait_idle();
  endtask

  // receiver holds off while values keep coming; long list without restart
  task automatic test_pressure();
    write_reg(PGVE_CFG_APPLY_DELTA, 1'b1);
    write_reg(PGVE_CFG_BLOCK_RESTART, 1'b0);
    set_idling(0, 0, HOLD_CYCLES);
    send_lists(140, 130);
    wait_idle();
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = PGVE_CFG_APPLY_DELTA;
    cfg_wdata = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    n_fail = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    list_left = 0;
    stim_prev = '0;
    apply_delta_q = 1'b1;
    block_restart_q = 1'b0;
    prev_value_q = '0;
    block_pos_q = 0;
    in_list_q = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_config_mid_list();
    test_byte_lengths();
    test_block_restart();
    test_raw_random();
    test_pressure();

    repeat (10) @(posedge clk);
    if (n_fail == 0) begin
      $display("posting_gap_vbyte_encoder_core: match");
    end else begin
      $display("posting_gap_vbyte_encoder_core: mismatch");
    end
    $finish;
  end

endmodule
